>>> hdl/token_grammar_mask_generator_defines.svh
// Assertion macros shared by the checker of the token grammar mask generator.
// No dependencies.
`ifndef TOKEN_GRAMMAR_MASK_GENERATOR_DEFINES_SVH
`define TOKEN_GRAMMAR_MASK_GENERATOR_DEFINES_SVH
// implication checked every clock outside reset
`define TGM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication checked in the following cycle
`define TGM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> hdl/tgm_pkg.sv
// Package of the token grammar mask generator: type codes, widths, control structs.
// No dependencies.
`default_nettype none
package tgm_pkg;
    localparam int COUNT_BITS_DEF = 8;
    localparam int NTYPES = 34;
    localparam int LIMIT_MAX = 16383;

    localparam logic [5:0] K_TRACK = 6'd0;
    localparam logic [5:0] K_BAR = 6'd1;
    localparam logic [5:0] K_TSIG = 6'd2;
    localparam logic [5:0] K_BAREND = 6'd3;
    localparam logic [5:0] K_POS = 6'd4;
    localparam logic [5:0] K_FSTART = 6'd5;
    localparam logic [5:0] K_FEND = 6'd6;
    localparam logic [5:0] K_HSTART = 6'd7;
    localparam logic [5:0] K_HEND = 6'd8;
    localparam logic [5:0] K_SSTART = 6'd9;
    localparam logic [5:0] K_SEND = 6'd10;
    localparam logic [5:0] K_VEL = 6'd11;
    localparam logic [5:0] K_ONSET = 6'd12;
    localparam logic [5:0] K_PITCH = 6'd13;
    localparam logic [5:0] K_PSTART = 6'd14;
    localparam logic [5:0] K_NUMBARS = 6'd15;
    localparam logic [5:0] K_INSTR = 6'd16;
    localparam logic [5:0] K_TRACKEND = 6'd17;
    localparam logic [5:0] K_DENSITY = 6'd18;
    localparam logic [5:0] K_PITCHRANGE = 6'd24;
    localparam logic [5:0] K_TENSION = 6'd25;
    localparam logic [5:0] K_PCS = 6'd26;
    localparam logic [5:0] K_BLVR = 6'd27;
    localparam logic [5:0] K_MASKBAR = 6'd28;
    localparam logic [5:0] K_DDIR = 6'd29;
    localparam logic [5:0] K_DELTA = 6'd30;
    localparam logic [5:0] K_PLACE = 6'd31;
    localparam logic [5:0] K_PEND = 6'd32;
    localparam logic [5:0] K_DUR = 6'd33;

    // configuration register indexes
    localparam logic [2:0] R_EXACT_BARS = 3'd0;
    localparam logic [2:0] R_TRACK_LIMIT = 3'd1;
    localparam logic [2:0] R_HUM_TOTAL = 3'd2;
    localparam logic [2:0] R_TICKS = 3'd3;
    localparam logic [2:0] R_MODE = 3'd4;

    typedef logic [NTYPES-1:0] mask_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // latch input word and update state
        logic div_start; // begin beat-length division
        logic div_step;  // one restoring step
        logic finish;    // compute mask and window into output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_div;
        logic div_last;
    } stat_t;

    function automatic mask_t bit_of(input logic [5:0] k);
        mask_t m;
        m = '0;
        m[k] = 1'b1;
        return m;
    endfunction
endpackage
`default_nettype wire

>>> hdl/token_grammar_mask_generator.sv
// Top level of the token grammar mask generator: controller plus datapath.
// Depends on tgm_pkg, tgm_ctrl and tgm_datapath.
`default_nettype none
// One token word is taken at a time. A time-signature token with signatures
// enabled and a nonzero denominator also passes through the seven-step restoring
// divider that forms the beats per bar.
// A finished word sits in the output register; the next token is taken once
// the result is written there.
module token_grammar_mask_generator
#(
    parameter int COUNT_BITS = tgm_pkg::COUNT_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [5:0]         token_kind,
    input  wire logic [11:0]        token_value,
    input  wire logic [4:0]         sig_numerator,
    input  wire logic [4:0]         sig_denominator,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [33:0]             allowed_types,
    output logic                    window_active,
    output logic signed [12:0]      position_after,
    output logic [13:0]             position_limit,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [11:0]        cfg_data
);
    tgm_pkg::cmd_t  cmd;
    tgm_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    tgm_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .stat(stat)
    );

    tgm_datapath #(.COUNT_BITS(COUNT_BITS)) u_dp
    (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .token_kind(token_kind), .token_value(token_value),
        .sig_numerator(sig_numerator), .sig_denominator(sig_denominator),
        .cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .allowed_types(allowed_types), .window_active(window_active),
        .position_after(position_after), .position_limit(position_limit)
    );
endmodule
`default_nettype wire

>>> hdl/tgm_ctrl.sv
// Controller of the token grammar mask generator: sequences load, divide and finish.
// Depends on tgm_pkg.
`default_nettype none
module tgm_ctrl
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output tgm_pkg::cmd_t        cmd,
    input  wire tgm_pkg::stat_t  stat
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_FIN  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   acc;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign acc = in_valid && !in_stall;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (stat.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_FIN:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                // output register free: write result
                if (!out_valid_next)
                begin
                    cmd.finish = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule
`default_nettype wire

>>> hdl/tgm_datapath.sv
// Datapath of the token grammar mask generator: grammar state, beat divider, mask.
// Depends on tgm_pkg.
`default_nettype none
module tgm_datapath
#(
    parameter int COUNT_BITS = tgm_pkg::COUNT_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tgm_pkg::cmd_t      cmd,
    output tgm_pkg::stat_t          stat,
    input  wire logic [5:0]         token_kind,
    input  wire logic [11:0]        token_value,
    input  wire logic [4:0]         sig_numerator,
    input  wire logic [4:0]         sig_denominator,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [11:0]        cfg_data,
    output logic [33:0]             allowed_types,
    output logic                    window_active,
    output logic signed [12:0]      position_after,
    output logic [13:0]             position_limit
);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    // configuration
    logic signed [8:0] exact_reg, tlim_reg;
    logic [11:0] htot_reg;
    logic [7:0]  tpb_reg;
    logic [4:0]  mode_reg;

    // grammar state
    logic [5:0]  last_kind_reg;
    logic [COUNT_BITS-1:0] tracks_reg, bars_reg;
    logic        drum_reg, inbar_reg, notes_reg, fill_reg, hum_reg, skel_reg;
    logic signed [12:0] lastpos_reg;
    logic [6:0]  beats_reg;
    logic [11:0] hgroups_reg;

    // latched token parts and divider
    logic [4:0]  den_reg;
    logic [6:0]  dividend_reg;
    logic [6:0]  quo_reg;
    logic [4:0]  rem_reg;
    logic [2:0]  step_reg;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exact_reg <= -9'sd1;
            tlim_reg <= -9'sd1;
            htot_reg <= '0;
            tpb_reg <= 8'd12;
            mode_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tgm_pkg::R_EXACT_BARS:  exact_reg <= cfg_data[8:0];
                tgm_pkg::R_TRACK_LIMIT: tlim_reg <= cfg_data[8:0];
                tgm_pkg::R_HUM_TOTAL:   htot_reg <= cfg_data;
                tgm_pkg::R_TICKS:       tpb_reg <= cfg_data[7:0];
                tgm_pkg::R_MODE:        mode_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign stat.need_div = (last_kind_reg == tgm_pkg::K_TSIG) && mode_reg[4]
                           && (den_reg != 5'd0);
    assign stat.div_last = (step_reg == 3'd0);

    // restoring division step: 4*num/den, 7 quotient bits
    logic [5:0] trial;
    assign trial = {rem_reg, dividend_reg[6]} - {1'b0, den_reg};

    // grammar state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_kind_reg <= tgm_pkg::K_PSTART;
            tracks_reg <= '0;
            drum_reg <= 1'b0;
            bars_reg <= '0;
            inbar_reg <= 1'b0;
            lastpos_reg <= -13'sd1;
            beats_reg <= 7'd4;
            notes_reg <= 1'b0;
            fill_reg <= 1'b0;
            hum_reg <= 1'b0;
            hgroups_reg <= '0;
            skel_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (cmd.load)
        begin
            last_kind_reg <= token_kind;
            case (token_kind)
                tgm_pkg::K_TRACK:
                begin
                    if (tracks_reg != CMAX)
                        tracks_reg <= tracks_reg + 1'b1;
                    drum_reg <= (token_value == 12'd1);
                    bars_reg <= '0;
                end
                tgm_pkg::K_BAR:
                begin
                    if (bars_reg != CMAX)
                        bars_reg <= bars_reg + 1'b1;
                    inbar_reg <= 1'b1;
                    lastpos_reg <= -13'sd1;
                    beats_reg <= 7'd4;
                    notes_reg <= 1'b0;
                end
                tgm_pkg::K_BAREND: inbar_reg <= 1'b0;
                tgm_pkg::K_POS:    lastpos_reg <= $signed({1'b0, token_value});
                tgm_pkg::K_FSTART:
                begin
                    fill_reg <= 1'b1;
                    notes_reg <= 1'b0;
                    lastpos_reg <= -13'sd1;
                end
                tgm_pkg::K_FEND:   fill_reg <= 1'b0;
                tgm_pkg::K_HSTART:
                begin
                    hum_reg <= 1'b1;
                    hgroups_reg <= '0;
                end
                tgm_pkg::K_HEND:   hum_reg <= 1'b0;
                tgm_pkg::K_SSTART: skel_reg <= 1'b1;
                tgm_pkg::K_SEND:   skel_reg <= 1'b0;
                tgm_pkg::K_VEL:
                begin
                    if (hum_reg && hgroups_reg != 12'hFFF)
                        hgroups_reg <= hgroups_reg + 1'b1;
                end
                tgm_pkg::K_ONSET, tgm_pkg::K_PITCH: notes_reg <= 1'b1;
                default: ;
            endcase
        end
        else if (cmd.div_start)
        begin
            step_reg <= 3'd6;
        end
        else if (cmd.div_step)
        begin
            if (step_reg != 3'd0)
                step_reg <= step_reg - 1'b1;
            else
                beats_reg <= {quo_reg[5:0], ~trial[5]};
        end
    end

    // divider registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            den_reg <= sig_denominator;
            dividend_reg <= {sig_numerator, 2'b00};
        end
        else if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dividend_reg <= {dividend_reg[5:0], 1'b0};
            quo_reg <= {quo_reg[5:0], ~trial[5]};
            rem_reg <= trial[5] ? {rem_reg[3:0], dividend_reg[6]} : trial[4:0];
        end
    end

    // grammar mask
    logic end_ok;
    logic bars_lt, tracks_lt;
    tgm_pkg::mask_t m, bar_or_end, bar_body, after_note, hum_next;
    logic [5:0] k;

    always_comb
    begin
        end_ok = !mode_reg[0] || notes_reg;
        bars_lt = ($signed({1'b0, bars_reg}) < exact_reg);
        tracks_lt = ($signed({1'b0, tracks_reg}) < tlim_reg);
        if (exact_reg < 0)
            bar_or_end = tgm_pkg::bit_of(tgm_pkg::K_BAR) | tgm_pkg::bit_of(tgm_pkg::K_TRACKEND);
        else if (bars_lt)
            bar_or_end = tgm_pkg::bit_of(tgm_pkg::K_BAR);
        else
            bar_or_end = tgm_pkg::bit_of(tgm_pkg::K_TRACKEND);
        bar_body = tgm_pkg::bit_of(tgm_pkg::K_TENSION) | tgm_pkg::bit_of(tgm_pkg::K_PCS)
                 | tgm_pkg::bit_of(tgm_pkg::K_BLVR) | tgm_pkg::bit_of(tgm_pkg::K_MASKBAR)
                 | tgm_pkg::bit_of(tgm_pkg::K_POS) | tgm_pkg::bit_of(tgm_pkg::K_VEL)
                 | tgm_pkg::bit_of(tgm_pkg::K_ONSET) | tgm_pkg::bit_of(tgm_pkg::K_PITCH)
                 | tgm_pkg::bit_of(tgm_pkg::K_DDIR) | tgm_pkg::bit_of(tgm_pkg::K_DELTA)
                 | tgm_pkg::bit_of(tgm_pkg::K_SSTART);
        if (end_ok)
            bar_body = bar_body | tgm_pkg::bit_of(tgm_pkg::K_BAREND);
        if (skel_reg)
            after_note = tgm_pkg::bit_of(tgm_pkg::K_ONSET) | tgm_pkg::bit_of(tgm_pkg::K_PITCH)
                       | tgm_pkg::bit_of(tgm_pkg::K_POS) | tgm_pkg::bit_of(tgm_pkg::K_SEND);
        else
            after_note = tgm_pkg::bit_of(tgm_pkg::K_VEL) | tgm_pkg::bit_of(tgm_pkg::K_ONSET)
                       | tgm_pkg::bit_of(tgm_pkg::K_PITCH) | tgm_pkg::bit_of(tgm_pkg::K_POS)
                       | tgm_pkg::bit_of(tgm_pkg::K_DDIR) | tgm_pkg::bit_of(tgm_pkg::K_DELTA)
                       | (fill_reg ? tgm_pkg::bit_of(tgm_pkg::K_FEND)
                                   : tgm_pkg::bit_of(tgm_pkg::K_BAREND));
        hum_next = (hgroups_reg < htot_reg) ? tgm_pkg::bit_of(tgm_pkg::K_VEL)
                                            : tgm_pkg::bit_of(tgm_pkg::K_HEND);
        k = last_kind_reg;
        // attribute control kinds behave like instrument
        if (k >= tgm_pkg::K_DENSITY && k <= tgm_pkg::K_PITCHRANGE)
            k = tgm_pkg::K_INSTR;
        case (k)
            tgm_pkg::K_PSTART:
                m = tgm_pkg::bit_of(tgm_pkg::K_NUMBARS) | tgm_pkg::bit_of(tgm_pkg::K_TRACK);
            tgm_pkg::K_NUMBARS: m = tgm_pkg::bit_of(tgm_pkg::K_TRACK);
            tgm_pkg::K_TRACK:   m = tgm_pkg::bit_of(tgm_pkg::K_INSTR) | bar_or_end;
            tgm_pkg::K_INSTR:   m = tgm_pkg::mask_t'(34'h1FC0000) | bar_or_end;
            tgm_pkg::K_BAR:
                m = tgm_pkg::bit_of(tgm_pkg::K_TSIG) | bar_body
                  | tgm_pkg::bit_of(tgm_pkg::K_PLACE);
            tgm_pkg::K_TSIG:    m = bar_body | tgm_pkg::bit_of(tgm_pkg::K_PLACE);
            tgm_pkg::K_TENSION, tgm_pkg::K_PCS, tgm_pkg::K_BLVR: m = bar_body;
            tgm_pkg::K_MASKBAR, tgm_pkg::K_PLACE, tgm_pkg::K_SEND:
                m = tgm_pkg::bit_of(tgm_pkg::K_BAREND);
            tgm_pkg::K_BAREND:
            begin
                m = tgm_pkg::bit_of(tgm_pkg::K_FSTART);
                if (exact_reg < 0)
                    m = m | tgm_pkg::bit_of(tgm_pkg::K_TRACKEND)
                          | tgm_pkg::bit_of(tgm_pkg::K_PEND) | tgm_pkg::bit_of(tgm_pkg::K_BAR);
                else if (bars_lt)
                    m = m | tgm_pkg::bit_of(tgm_pkg::K_BAR);
                else
                    m = m | tgm_pkg::bit_of(tgm_pkg::K_TRACKEND)
                          | tgm_pkg::bit_of(tgm_pkg::K_PEND);
            end
            tgm_pkg::K_POS:
            begin
                if (skel_reg)
                begin
                    m = tgm_pkg::bit_of(tgm_pkg::K_ONSET) | tgm_pkg::bit_of(tgm_pkg::K_PITCH);
                    if (end_ok)
                        m = m | tgm_pkg::bit_of(tgm_pkg::K_SEND);
                end
                else
                begin
                    m = tgm_pkg::bit_of(tgm_pkg::K_VEL) | tgm_pkg::bit_of(tgm_pkg::K_ONSET)
                      | tgm_pkg::bit_of(tgm_pkg::K_PITCH) | tgm_pkg::bit_of(tgm_pkg::K_DDIR)
                      | tgm_pkg::bit_of(tgm_pkg::K_DELTA);
                    if (end_ok)
                        m = m | (fill_reg ? tgm_pkg::bit_of(tgm_pkg::K_FEND)
                                          : tgm_pkg::bit_of(tgm_pkg::K_BAREND));
                end
            end
            tgm_pkg::K_VEL:
            begin
                if (hum_reg)
                    m = tgm_pkg::bit_of(tgm_pkg::K_DDIR) | tgm_pkg::bit_of(tgm_pkg::K_DELTA)
                      | hum_next;
                else
                    m = tgm_pkg::bit_of(tgm_pkg::K_ONSET) | tgm_pkg::bit_of(tgm_pkg::K_PITCH)
                      | tgm_pkg::bit_of(tgm_pkg::K_DELTA);
            end
            tgm_pkg::K_DDIR: m = tgm_pkg::bit_of(tgm_pkg::K_DELTA);
            tgm_pkg::K_DELTA:
            begin
                if (hum_reg)
                    m = hum_next;
                else
                begin
                    m = tgm_pkg::bit_of(tgm_pkg::K_DELTA) | tgm_pkg::bit_of(tgm_pkg::K_DDIR)
                      | tgm_pkg::bit_of(tgm_pkg::K_ONSET) | tgm_pkg::bit_of(tgm_pkg::K_PITCH);
                    if (fill_reg && end_ok)
                        m = m | tgm_pkg::bit_of(tgm_pkg::K_FEND);
                end
            end
            tgm_pkg::K_ONSET, tgm_pkg::K_PITCH:
                m = drum_reg ? after_note : tgm_pkg::bit_of(tgm_pkg::K_DUR);
            tgm_pkg::K_DUR: m = after_note;
            tgm_pkg::K_TRACKEND:
            begin
                m = tgm_pkg::bit_of(tgm_pkg::K_PEND);
                if (tlim_reg < 0 || tracks_lt)
                    m = m | tgm_pkg::bit_of(tgm_pkg::K_TRACK);
            end
            tgm_pkg::K_FSTART:
                m = tgm_pkg::bit_of(tgm_pkg::K_POS) | tgm_pkg::bit_of(tgm_pkg::K_VEL)
                  | tgm_pkg::bit_of(tgm_pkg::K_ONSET) | tgm_pkg::bit_of(tgm_pkg::K_PITCH)
                  | tgm_pkg::bit_of(tgm_pkg::K_DDIR) | tgm_pkg::bit_of(tgm_pkg::K_DELTA);
            tgm_pkg::K_FEND:
                m = tgm_pkg::bit_of(tgm_pkg::K_BAREND) | tgm_pkg::bit_of(tgm_pkg::K_FSTART)
                  | tgm_pkg::bit_of(tgm_pkg::K_HSTART) | tgm_pkg::bit_of(tgm_pkg::K_PEND);
            tgm_pkg::K_HSTART:
                m = (htot_reg != '0) ? tgm_pkg::bit_of(tgm_pkg::K_VEL)
                                     : tgm_pkg::bit_of(tgm_pkg::K_HEND);
            tgm_pkg::K_HEND:
                m = tgm_pkg::bit_of(tgm_pkg::K_HSTART) | tgm_pkg::bit_of(tgm_pkg::K_PEND);
            tgm_pkg::K_SSTART:
            begin
                m = tgm_pkg::bit_of(tgm_pkg::K_POS) | tgm_pkg::bit_of(tgm_pkg::K_ONSET)
                  | tgm_pkg::bit_of(tgm_pkg::K_PITCH);
                if (end_ok)
                    m = m | tgm_pkg::bit_of(tgm_pkg::K_SEND);
            end
            default: m = '1;
        endcase
        // mode masks
        if (mode_reg[1])
            m = m & ~(tgm_pkg::bit_of(tgm_pkg::K_FSTART) | tgm_pkg::bit_of(tgm_pkg::K_FEND)
                    | tgm_pkg::bit_of(tgm_pkg::K_PLACE) | tgm_pkg::bit_of(tgm_pkg::K_HSTART)
                    | tgm_pkg::bit_of(tgm_pkg::K_HEND) | tgm_pkg::bit_of(tgm_pkg::K_SSTART)
                    | tgm_pkg::bit_of(tgm_pkg::K_SEND));
        if (mode_reg[2])
            m = m & ~tgm_pkg::bit_of(tgm_pkg::K_TRACK);
        if (mode_reg[3])
            m = m & ~tgm_pkg::bit_of(tgm_pkg::K_TRACKEND);
    end

    // bar length in ticks, saturated to LIMIT_MAX in the output register
    logic [14:0] ticks;
    assign ticks = beats_reg * tpb_reg;

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            allowed_types <= m;
            window_active <= inbar_reg;
            position_after <= inbar_reg ? lastpos_reg : 13'sd0;
            position_limit <= !inbar_reg ? 14'd0
                            : (ticks > 15'(tgm_pkg::LIMIT_MAX)) ? 14'(tgm_pkg::LIMIT_MAX)
                            : ticks[13:0];
        end
    end
endmodule
`default_nettype wire

>>> hdl/tgm_checker.sv
// Port checker for the token grammar mask generator, bound to the top level.
// Depends on token_grammar_mask_generator_defines.svh.
`default_nettype none
`include "token_grammar_mask_generator_defines.svh"
module tgm_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        window_active,
    input wire logic [12:0] position_after,
    input wire logic [13:0] position_limit
);
    // one token in flight: after acceptance input stalls
    `TGM_ASSERT_NEXT(a_busy, in_valid && !in_stall, in_stall)
    // closed window reports zeros
    `TGM_ASSERT_IMP(a_closed, out_valid && !window_active, position_after == 13'd0 && position_limit == 14'd0)
    // result still valid and position limit held while stalled
    `TGM_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(position_limit))
endmodule
bind token_grammar_mask_generator tgm_checker u_tgm_checker
(
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .window_active(window_active),
    .position_after(position_after), .position_limit(position_limit)
);
`default_nettype wire
